// ===== sv/shp_pkg.sv =====
package shp_pkg;

  localparam int COORD_WIDTH_DEF = 16;

  localparam logic KIND_CIRCLE = 1'b0;
  localparam logic KIND_RECT   = 1'b1;

  typedef enum logic [1:0] {
    MODE_CC = 2'd0,
    MODE_RR = 2'd1,
    MODE_CR = 2'd2
  } mode_t;

endpackage

// ===== sv/shape_pair_intersection_top.sv =====
// Channel   Handshake              Payload
// input     in_valid / in_ready    in_first_*, in_second_* (kind, x0, y0, x1, y1, radius)
// result    out_valid / out_ready  out_overlap
//
// One shape pair is taken in every cycle unless a stall on out_ready holds the pipeline full.
// The four register stages are role selection with clamping, absolute differences,
// squaring, and the final sum and compare; the squaring multipliers set the stage depth.
// Reset clears the stage valid bits only; the stage data registers are not reset.
// A stage holds its item while the stage after it cannot take it, so a stall on out_ready
// fills the empty stages first and loses or repeats no item.
module shape_pair_intersection_top
  import shp_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_first_kind,
  input  logic signed [COORD_WIDTH-1:0] in_first_x0,
  input  logic signed [COORD_WIDTH-1:0] in_first_y0,
  input  logic signed [COORD_WIDTH-1:0] in_first_x1,
  input  logic signed [COORD_WIDTH-1:0] in_first_y1,
  input  logic        [COORD_WIDTH-2:0] in_first_radius,
  input  logic                          in_second_kind,
  input  logic signed [COORD_WIDTH-1:0] in_second_x0,
  input  logic signed [COORD_WIDTH-1:0] in_second_y0,
  input  logic signed [COORD_WIDTH-1:0] in_second_x1,
  input  logic signed [COORD_WIDTH-1:0] in_second_y1,
  input  logic        [COORD_WIDTH-2:0] in_second_radius,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_overlap
);

  localparam int CW = COORD_WIDTH;

  logic                 s1_valid, s1_ready;
  mode_t                s1_mode;
  logic                 s1_rr_hit;
  logic signed [CW-1:0] s1_cx, s1_cy, s1_px, s1_py;
  logic        [CW-1:0] s1_r;

  logic                 s2_valid, s2_ready;
  mode_t                s2_mode;
  logic                 s2_rr_hit;
  logic        [CW:0]   s2_dx, s2_dy;
  logic        [CW-1:0] s2_r;

  logic                 s3_valid, s3_ready;
  mode_t                s3_mode;
  logic                 s3_rr_hit;
  logic      [2*CW+1:0] s3_dx2, s3_dy2;
  logic      [2*CW-1:0] s3_r2;

  shp_select #(.COORD_WIDTH(COORD_WIDTH)) u_select (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .first_kind    (in_first_kind),
    .first_x0      (in_first_x0),
    .first_y0      (in_first_y0),
    .first_x1      (in_first_x1),
    .first_y1      (in_first_y1),
    .first_radius  (in_first_radius),
    .second_kind   (in_second_kind),
    .second_x0     (in_second_x0),
    .second_y0     (in_second_y0),
    .second_x1     (in_second_x1),
    .second_y1     (in_second_y1),
    .second_radius (in_second_radius),
    .out_valid     (s1_valid),
    .out_ready     (s1_ready),
    .mode_o        (s1_mode),
    .rr_hit_o      (s1_rr_hit),
    .cx_o          (s1_cx),
    .cy_o          (s1_cy),
    .px_o          (s1_px),
    .py_o          (s1_py),
    .r_o           (s1_r)
  );

  shp_dist #(.COORD_WIDTH(COORD_WIDTH)) u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .mode_i    (s1_mode),
    .rr_hit_i  (s1_rr_hit),
    .cx_i      (s1_cx),
    .cy_i      (s1_cy),
    .px_i      (s1_px),
    .py_i      (s1_py),
    .r_i       (s1_r),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .mode_o    (s2_mode),
    .rr_hit_o  (s2_rr_hit),
    .dx_o      (s2_dx),
    .dy_o      (s2_dy),
    .r_o       (s2_r)
  );

  shp_square #(.COORD_WIDTH(COORD_WIDTH)) u_square (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .mode_i    (s2_mode),
    .rr_hit_i  (s2_rr_hit),
    .dx_i      (s2_dx),
    .dy_i      (s2_dy),
    .r_i       (s2_r),
    .out_valid (s3_valid),
    .out_ready (s3_ready),
    .mode_o    (s3_mode),
    .rr_hit_o  (s3_rr_hit),
    .dx2_o     (s3_dx2),
    .dy2_o     (s3_dy2),
    .r2_o      (s3_r2)
  );

  shp_compare #(.COORD_WIDTH(COORD_WIDTH)) u_compare (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_valid),
    .in_ready  (s3_ready),
    .mode_i    (s3_mode),
    .rr_hit_i  (s3_rr_hit),
    .dx2_i     (s3_dx2),
    .dy2_i     (s3_dy2),
    .r2_i      (s3_r2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .overlap_o (out_overlap)
  );

endmodule

// ===== sv/shp_select.sv =====
module shp_select
  import shp_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          first_kind,
  input  logic signed [COORD_WIDTH-1:0] first_x0,
  input  logic signed [COORD_WIDTH-1:0] first_y0,
  input  logic signed [COORD_WIDTH-1:0] first_x1,
  input  logic signed [COORD_WIDTH-1:0] first_y1,
  input  logic        [COORD_WIDTH-2:0] first_radius,
  input  logic                          second_kind,
  input  logic signed [COORD_WIDTH-1:0] second_x0,
  input  logic signed [COORD_WIDTH-1:0] second_y0,
  input  logic signed [COORD_WIDTH-1:0] second_x1,
  input  logic signed [COORD_WIDTH-1:0] second_y1,
  input  logic        [COORD_WIDTH-2:0] second_radius,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mode_t                         mode_o,
  output logic                          rr_hit_o,
  output logic signed [COORD_WIDTH-1:0] cx_o,
  output logic signed [COORD_WIDTH-1:0] cy_o,
  output logic signed [COORD_WIDTH-1:0] px_o,
  output logic signed [COORD_WIDTH-1:0] py_o,
  output logic        [COORD_WIDTH-1:0] r_o
);

  localparam int CW = COORD_WIDTH;

  logic                 valid_r;
  mode_t                mode_r, mode_nxt;
  logic                 rr_hit_r, rr_hit_nxt;
  logic signed [CW-1:0] cx_r, cy_r, px_r, py_r;
  logic signed [CW-1:0] cx_nxt, cy_nxt, px_nxt, py_nxt;
  logic        [CW-1:0] r_r, r_nxt;
  logic signed [CW-1:0] lx, ly, hx, hy, tx, ty;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    rr_hit_nxt = (first_x1 >= second_x0) && (first_x0 <= second_x1) &&
                 (first_y1 >= second_y0) && (first_y0 <= second_y1);
    if (first_kind == KIND_CIRCLE && second_kind == KIND_CIRCLE) begin
      mode_nxt = MODE_CC;
    end else if (first_kind == KIND_RECT && second_kind == KIND_RECT) begin
      mode_nxt = MODE_RR;
    end else begin
      mode_nxt = MODE_CR;
    end
    if (first_kind == KIND_CIRCLE) begin
      cx_nxt = first_x0;
      cy_nxt = first_y0;
      lx = second_x0;
      ly = second_y0;
      hx = second_x1;
      hy = second_y1;
    end else begin
      cx_nxt = second_x0;
      cy_nxt = second_y0;
      lx = first_x0;
      ly = first_y0;
      hx = first_x1;
      hy = first_y1;
    end
    tx = (cx_nxt < hx) ? cx_nxt : hx;
    ty = (cy_nxt < hy) ? cy_nxt : hy;
    if (mode_nxt == MODE_CC) begin
      px_nxt = second_x0;
      py_nxt = second_y0;
      r_nxt  = {1'b0, first_radius} + {1'b0, second_radius};
    end else begin
      px_nxt = (tx > lx) ? tx : lx;
      py_nxt = (ty > ly) ? ty : ly;
      r_nxt  = (first_kind == KIND_CIRCLE) ? {1'b0, first_radius} : {1'b0, second_radius};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r   <= mode_nxt;
      rr_hit_r <= rr_hit_nxt;
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      px_r     <= px_nxt;
      py_r     <= py_nxt;
      r_r      <= r_nxt;
    end
  end

  assign out_valid = valid_r;
  assign mode_o    = mode_r;
  assign rr_hit_o  = rr_hit_r;
  assign cx_o      = cx_r;
  assign cy_o      = cy_r;
  assign px_o      = px_r;
  assign py_o      = py_r;
  assign r_o       = r_r;

endmodule

// ===== sv/shp_dist.sv =====
module shp_dist
  import shp_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mode_t                         mode_i,
  input  logic                          rr_hit_i,
  input  logic signed [COORD_WIDTH-1:0] cx_i,
  input  logic signed [COORD_WIDTH-1:0] cy_i,
  input  logic signed [COORD_WIDTH-1:0] px_i,
  input  logic signed [COORD_WIDTH-1:0] py_i,
  input  logic        [COORD_WIDTH-1:0] r_i,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mode_t                         mode_o,
  output logic                          rr_hit_o,
  output logic        [COORD_WIDTH:0]   dx_o,
  output logic        [COORD_WIDTH:0]   dy_o,
  output logic        [COORD_WIDTH-1:0] r_o
);

  localparam int CW = COORD_WIDTH;

  logic               valid_r;
  mode_t              mode_r;
  logic               rr_hit_r;
  logic        [CW:0] dx_r, dy_r, dx_nxt, dy_nxt;
  logic        [CW-1:0] r_r;
  logic signed [CW:0] diff_x, diff_y;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    diff_x = {cx_i[CW-1], cx_i} - {px_i[CW-1], px_i};
    diff_y = {cy_i[CW-1], cy_i} - {py_i[CW-1], py_i};
    dx_nxt = diff_x[CW] ? (CW+1)'(-diff_x) : (CW+1)'(diff_x);
    dy_nxt = diff_y[CW] ? (CW+1)'(-diff_y) : (CW+1)'(diff_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r   <= mode_i;
      rr_hit_r <= rr_hit_i;
      dx_r     <= dx_nxt;
      dy_r     <= dy_nxt;
      r_r      <= r_i;
    end
  end

  assign out_valid = valid_r;
  assign mode_o    = mode_r;
  assign rr_hit_o  = rr_hit_r;
  assign dx_o      = dx_r;
  assign dy_o      = dy_r;
  assign r_o       = r_r;

endmodule

// ===== sv/shp_square.sv =====
module shp_square
  import shp_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  mode_t                      mode_i,
  input  logic                       rr_hit_i,
  input  logic [COORD_WIDTH:0]       dx_i,
  input  logic [COORD_WIDTH:0]       dy_i,
  input  logic [COORD_WIDTH-1:0]     r_i,
  output logic                       out_valid,
  input  logic                       out_ready,
  output mode_t                      mode_o,
  output logic                       rr_hit_o,
  output logic [2*COORD_WIDTH+1:0]   dx2_o,
  output logic [2*COORD_WIDTH+1:0]   dy2_o,
  output logic [2*COORD_WIDTH-1:0]   r2_o
);

  localparam int CW = COORD_WIDTH;

  logic            valid_r;
  mode_t           mode_r;
  logic            rr_hit_r;
  logic [2*CW+1:0] dx2_r, dy2_r, dx2_nxt, dy2_nxt;
  logic [2*CW-1:0] r2_r, r2_nxt;

  assign in_ready = !valid_r || out_ready;

  assign dx2_nxt = (2*CW+2)'(dx_i) * (2*CW+2)'(dx_i);
  assign dy2_nxt = (2*CW+2)'(dy_i) * (2*CW+2)'(dy_i);
  assign r2_nxt  = (2*CW)'(r_i) * (2*CW)'(r_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r   <= mode_i;
      rr_hit_r <= rr_hit_i;
      dx2_r    <= dx2_nxt;
      dy2_r    <= dy2_nxt;
      r2_r     <= r2_nxt;
    end
  end

  assign out_valid = valid_r;
  assign mode_o    = mode_r;
  assign rr_hit_o  = rr_hit_r;
  assign dx2_o     = dx2_r;
  assign dy2_o     = dy2_r;
  assign r2_o      = r2_r;

endmodule

// ===== sv/shp_compare.sv =====
module shp_compare
  import shp_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  mode_t                    mode_i,
  input  logic                     rr_hit_i,
  input  logic [2*COORD_WIDTH+1:0] dx2_i,
  input  logic [2*COORD_WIDTH+1:0] dy2_i,
  input  logic [2*COORD_WIDTH-1:0] r2_i,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     overlap_o
);

  localparam int CW = COORD_WIDTH;

  logic            valid_r;
  logic            overlap_r, overlap_nxt;
  logic [2*CW+2:0] sum;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    sum = {1'b0, dx2_i} + {1'b0, dy2_i};
    if (mode_i == MODE_RR) begin
      overlap_nxt = rr_hit_i;
    end else begin
      overlap_nxt = (sum <= {3'b000, r2_i});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      overlap_r <= overlap_nxt;
    end
  end

  assign out_valid = valid_r;
  assign overlap_o = overlap_r;

endmodule
